// ===== src/ops_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the overload protection supervisor.
// No dependencies.
package ops_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned DataWidth  = 32;

    typedef logic [CountWidth-1:0] count_t;
    typedef logic [7:0]            s_tdata_t;
    typedef logic [7:0]            m_tdata_t;
    typedef logic [AddrWidth-1:0]  paddr_t;
    typedef logic [DataWidth-1:0]  pdata_t;

    typedef enum logic {
        REG_BLANKING_TICKS = 1'b0,
        REG_OVERLOAD_TICKS = 1'b1
    } reg_index_t;

    localparam count_t BlankingTicksReset = 16'd100;
    localparam count_t OverloadTicksReset = 16'd10;

    // Input request fields, from bit 0 up.
    localparam int unsigned InOverloadActive = 0;
    localparam int unsigned InResetOverload  = 1;
    localparam int unsigned InOffReq         = 2;
    localparam int unsigned InOnReq          = 3;
    localparam int unsigned InAdcOffReq      = 4;
    localparam int unsigned InAdcOnReq       = 5;

endpackage

// ===== src/overload_protection_supervisor.sv =====
`timescale 1ns / 1ps
// The result of an accepted request is registered into m_tdata at the edge that accepts it.
// Throughput: one request per cycle while m_tready is high; the result register frees as it is taken.
// The counter and flag update is one combinational pass into the state and result registers.
// Reset (aresetn low, synchronous): counters and flags clear, registers load 100 and 10,
// no result pending.
// Depends on ops_pkg.
module overload_protection_supervisor (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [0] overload_active, [1] reset_overload_req, [2] off_req, [3] on_req,
    // [4] adc_off_req, [5] adc_on_req, [7:6] zero
    input  ops_pkg::s_tdata_t s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] drive_on, [1] status_on, [2] status_overloaded, [3] status_adc_hold, [7:4] zero
    output ops_pkg::m_tdata_t m_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  ops_pkg::paddr_t  paddr,
    input  ops_pkg::pdata_t  pwdata,
    output ops_pkg::pdata_t  prdata,
    output logic             pready
);
    import ops_pkg::*;

    count_t     blanking_ticks_reg;
    count_t     overload_ticks_reg;
    count_t     blank_count_reg, blank_count_next;
    count_t     overload_count_reg, overload_count_next;
    logic       on_flag_reg, on_flag_next;
    logic       overloaded_reg, overloaded_next;
    logic       adc_hold_reg, adc_hold_next;
    logic       m_valid_reg;
    m_tdata_t   m_data_reg;
    logic       accept;
    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_index)
            REG_BLANKING_TICKS: prdata = {{(DataWidth-CountWidth){1'b0}}, blanking_ticks_reg};
            REG_OVERLOAD_TICKS: prdata = {{(DataWidth-CountWidth){1'b0}}, overload_ticks_reg};
            default:            prdata = '0;
        endcase
    end

    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        if (!on_flag_reg || adc_hold_reg) begin
            blank_count_next = blanking_ticks_reg;
        end else if (blank_count_reg != '0) begin
            blank_count_next = blank_count_reg - count_t'(1);
        end else begin
            blank_count_next = '0;
        end

        if (blank_count_next != '0 || s_tdata[InOverloadActive]) begin
            overload_count_next = overload_ticks_reg;
        end else if (overload_count_reg != '0) begin
            overload_count_next = overload_count_reg - count_t'(1);
        end else begin
            overload_count_next = '0;
        end

        on_flag_next    = on_flag_reg;
        overloaded_next = overloaded_reg;
        if (overload_count_next == '0) begin
            on_flag_next    = 1'b0;
            overloaded_next = 1'b1;
        end
        if (s_tdata[InResetOverload]) begin
            overloaded_next = 1'b0;
        end
        if (!overloaded_next) begin
            if (s_tdata[InOffReq]) begin
                on_flag_next = 1'b0;
            end else if (s_tdata[InOnReq]) begin
                on_flag_next = 1'b1;
            end
        end

        if (s_tdata[InAdcOffReq]) begin
            adc_hold_next = 1'b1;
        end else if (s_tdata[InAdcOnReq]) begin
            adc_hold_next = 1'b0;
        end else begin
            adc_hold_next = adc_hold_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blanking_ticks_reg <= BlankingTicksReset;
            overload_ticks_reg <= OverloadTicksReset;
            blank_count_reg    <= '0;
            overload_count_reg <= '0;
            on_flag_reg        <= 1'b0;
            overloaded_reg     <= 1'b0;
            adc_hold_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_BLANKING_TICKS: blanking_ticks_reg <= pwdata[CountWidth-1:0];
                    REG_OVERLOAD_TICKS: overload_ticks_reg <= pwdata[CountWidth-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                blank_count_reg    <= blank_count_next;
                overload_count_reg <= overload_count_next;
                on_flag_reg        <= on_flag_next;
                overloaded_reg     <= overloaded_next;
                adc_hold_reg       <= adc_hold_next;
                m_valid_reg        <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {4'b0000, adc_hold_next, overloaded_next, on_flag_next,
                           on_flag_next & ~adc_hold_next};
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for overload_protection_supervisor: each status result is checked by a
// tick predictor or against a typed directed value; directed table first, then random
// command phases over several register settings. Depends on ops_pkg and the supervisor RTL.
module testbench;
    import ops_pkg::*;

    localparam s_tdata_t ReqOverload = s_tdata_t'(1 << InOverloadActive);
    localparam s_tdata_t ReqReset    = s_tdata_t'(1 << InResetOverload);
    localparam s_tdata_t ReqOff      = s_tdata_t'(1 << InOffReq);
    localparam s_tdata_t ReqOn       = s_tdata_t'(1 << InOnReq);
    localparam s_tdata_t ReqAdcOff   = s_tdata_t'(1 << InAdcOffReq);
    localparam s_tdata_t ReqAdcOn    = s_tdata_t'(1 << InAdcOnReq);
    localparam s_tdata_t ReqAll      = 8'h3F;

    localparam int DirectedRows = 23;
    localparam int Phases       = 10;
    localparam int PhaseItems   = 200;

    typedef struct packed {
        logic     is_setting;
        s_tdata_t req;
        logic     typed;
        m_tdata_t want;
        count_t   blank;
        count_t   ovl;
    } step_t;

    localparam step_t Directed [DirectedRows] = '{
        '{1'b0, 8'h00,                 1'b1, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqOn,                 1'b1, 8'h03, 16'd0,     16'd0},
        '{1'b0, ReqAdcOff,             1'b1, 8'h0A, 16'd0,     16'd0},
        '{1'b0, ReqAdcOff | ReqAdcOn,  1'b1, 8'h0A, 16'd0,     16'd0},
        '{1'b0, ReqAdcOn,              1'b1, 8'h03, 16'd0,     16'd0},
        '{1'b0, ReqOff | ReqOn,        1'b1, 8'h00, 16'd0,     16'd0},
        '{1'b1, 8'h00,                 1'b0, 8'h00, 16'd1,     16'd1},
        '{1'b0, ReqOn,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, 8'h00,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqOn,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqReset | ReqOn,      1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqOverload,           1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqReset | ReqOn,      1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, 8'h00,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b1, 8'h00,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqReset,              1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqReset | ReqOn,      1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, 8'h00,                 1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b1, 8'h00,                 1'b0, 8'h00, 16'hFFFF,  16'hFFFF},
        '{1'b0, ReqReset | ReqOn,      1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqAll,                1'b0, 8'h00, 16'd0,     16'd0},
        '{1'b0, ReqOverload | ReqAdcOn, 1'b0, 8'h00, 16'd0,    16'd0},
        '{1'b0, ReqOn,                 1'b0, 8'h00, 16'd0,     16'd0}
    };

    logic     aclk     = 1'b0;
    logic     aresetn  = 1'b0;
    logic     s_tvalid = 1'b0;
    logic     s_tready;
    s_tdata_t s_tdata  = '0;
    logic     m_tvalid;
    logic     m_tready = 1'b0;
    m_tdata_t m_tdata;
    logic     psel     = 1'b0;
    logic     penable  = 1'b0;
    logic     pwrite   = 1'b0;
    paddr_t   paddr    = '0;
    pdata_t   pwdata   = '0;
    pdata_t   prdata;
    logic     pready;

    count_t blank_reload = BlankingTicksReset;
    count_t ovl_reload   = OverloadTicksReset;
    count_t blank_left   = '0;
    count_t ovl_left     = '0;
    logic   conv_on      = 1'b0;
    logic   tripped      = 1'b0;
    logic   adc_hold     = 1'b0;

    m_tdata_t status_due [$];
    m_tdata_t due_status;
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    string    field_name [4] = '{"drive_on", "status_on", "status_overloaded",
                                 "status_adc_hold"};

    overload_protection_supervisor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    function automatic m_tdata_t supervise_tick(s_tdata_t req);
        m_tdata_t status;
        if (!conv_on || adc_hold) begin
            blank_left = blank_reload;
        end else if (blank_left != 0) begin
            blank_left = blank_left - 1'b1;
        end
        if (blank_left != 0 || req[InOverloadActive]) begin
            ovl_left = ovl_reload;
        end else if (ovl_left != 0) begin
            ovl_left = ovl_left - 1'b1;
        end
        if (ovl_left == 0) begin
            conv_on = 1'b0;
            tripped = 1'b1;
        end
        if (req[InResetOverload]) begin
            tripped = 1'b0;
        end
        if (!tripped) begin
            if (req[InOffReq]) begin
                conv_on = 1'b0;
            end else if (req[InOnReq]) begin
                conv_on = 1'b1;
            end
        end
        if (req[InAdcOffReq]) begin
            adc_hold = 1'b1;
        end else if (req[InAdcOnReq]) begin
            adc_hold = 1'b0;
        end
        status = '0;
        status[0] = conv_on && !adc_hold;
        status[1] = conv_on;
        status[2] = tripped;
        status[3] = adc_hold;
        return status;
    endfunction

    function automatic s_tdata_t draw_request(int ovl_pct);
        s_tdata_t req;
        req = '0;
        if ($urandom_range(0, 9) == 0) begin
            return s_tdata_t'($urandom_range(0, 63));
        end
        req[InOverloadActive] = ($urandom_range(0, 99) < ovl_pct);
        req[InResetOverload]  = ($urandom_range(0, 99) < 6);
        req[InOffReq]         = ($urandom_range(0, 99) < 8);
        req[InOnReq]          = ($urandom_range(0, 99) < 35);
        req[InAdcOffReq]      = ($urandom_range(0, 99) < 8);
        req[InAdcOnReq]       = ($urandom_range(0, 99) < 25);
        return req;
    endfunction

    task automatic send_request(s_tdata_t req, logic typed, m_tdata_t want);
        m_tdata_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        predicted = supervise_tick(req);
        status_due.push_back(typed ? want : predicted);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (status_due.size() != 0);
    endtask

    task automatic write_setting(reg_index_t idx, count_t value);
        hold_until_drained();
        repeat (3) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= paddr_t'({idx, 2'b00});
        pwdata  <= pdata_t'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== pdata_t'(value)) begin
            $display("%0t: register %s read back expected %h actual %h",
                     $time, idx.name(), pdata_t'(value), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_BLANKING_TICKS) begin
            blank_reload = value;
        end else begin
            ovl_reload = value;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                $display("%0t: unexpected status, expected none actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                due_status = status_due.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_tdata[f] !== due_status[f]) begin
                        $display("%0t: %s expected %b actual %b",
                                 $time, field_name[f], due_status[f], m_tdata[f]);
                        mismatches++;
                    end
                end
                if (m_tdata[7:4] !== 4'b0) begin
                    $display("%0t: padding expected 0 actual %h", $time, m_tdata[7:4]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        count_t blank_set [5] = '{16'd100, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF};
        count_t ovl_set   [5] = '{16'd10, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1};
        count_t blank_val;
        count_t ovl_val;
        int     ovl_pct;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (Directed[i]) begin
            if (Directed[i].is_setting) begin
                write_setting(REG_BLANKING_TICKS, Directed[i].blank);
                write_setting(REG_OVERLOAD_TICKS, Directed[i].ovl);
            end else begin
                send_request(Directed[i].req, Directed[i].typed, Directed[i].want);
            end
        end

        for (int phase = 0; phase < Phases; phase++) begin
            if (phase < 5) begin
                blank_val = blank_set[phase];
                ovl_val   = ovl_set[phase];
            end else begin
                blank_val = count_t'($urandom_range(1, 8));
                ovl_val   = count_t'($urandom_range(1, 6));
            end
            write_setting(REG_BLANKING_TICKS, blank_val);
            write_setting(REG_OVERLOAD_TICKS, ovl_val);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            ovl_pct = $urandom_range(2, 40);
            for (int n = 0; n < PhaseItems; n++) begin
                if (n == PhaseItems / 2) begin
                    hold_until_drained();
                end
                send_request(draw_request(ovl_pct), 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (5) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #4_800_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
